FILE: rtl/wsdf_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
package wsdf_pkg;

    // Parser phases; codes above PH_PAYLOAD are unused and parse as a first byte.
    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_SECOND  = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    // Result kinds carried on tuser.
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    localparam int unsigned LEN_W   = 63;
    localparam int unsigned TDATA_W = 80;   // 77 field bits padded to whole bytes

    // 7-bit length codes that announce an extended length.
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    // Header byte counts (bytes still to come after the current one).
    localparam logic [2:0] CNT_EXT16 = 3'd1;
    localparam logic [2:0] CNT_EXT64 = 3'd7;
    localparam logic [2:0] CNT_KEY   = 3'd3;

    typedef struct packed {
        logic             last;
        logic [7:0]       pbyte;
        logic [LEN_W-1:0] length;
        logic             masked;
        logic [3:0]       opcode;
        logic             fin;
        logic             kind;
    } t_result;

endpackage

FILE: rtl/websocket_frame_deframer_core.sv
// WebSocket (RFC 6455) receive-side frame deframer: header parse and payload unmasking.
//
//  channel   | dir | tdata                                   | tuser      | tlast
//  ----------+-----+-----------------------------------------+------------+--------------
//  s_axis    | in  | [7:0] raw stream byte                   | -          | -
//  m_axis    | out | fin, opcode, masked, length[62:0], byte | 0 hdr/1 pl | last of frame
//
//  One byte is taken per cycle while the skid entry is empty; each byte is parsed
//  in the cycle it transfers and any result lands on the same edge in the output
//  register, or in the skid entry when m_axis is stalled.
//  A two-entry output (register plus skid) absorbs one more result after m_axis
//  stalls; s_axis_tready drops only while the skid entry is full.
//  Reset (i_rst_n, synchronous, active low) returns the parser to the first
//  header byte and empties both output entries.
module websocket_frame_deframer_core
    import wsdf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] stream_byte
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [0] fin_flag, [4:1] frame_opcode, [5] masked_flag, [68:6] payload_length,
    // [76:69] payload_byte, [79:77] zero
    output logic [TDATA_W-1:0]   m_axis_tdata,
    output logic                 m_axis_tuser,   // [0] result_kind
    output logic                 m_axis_tlast    // last_of_frame
);

    // Parser state
    t_phase            r_phase,     n_phase;
    logic              r_fin,       n_fin;
    logic [3:0]        r_opcode,    n_opcode;
    logic              r_masked,    n_masked;
    logic [LEN_W-1:0]  r_len,       n_len;
    logic [2:0]        r_hcnt,      n_hcnt;
    logic [31:0]       r_key,       n_key;
    logic [LEN_W-1:0]  r_remain,    n_remain;
    logic [1:0]        r_kidx,      n_kidx;

    // Output register and skid entry
    logic              r_out_valid;
    t_result           r_out;
    logic              r_skid_valid;
    t_result           r_skid;

    logic              in_fire;
    logic              res_valid;
    t_result           res;
    logic [6:0]        len7;
    logic [7:0]        key_byte;
    logic [LEN_W-1:0]  remain_dec;

    assign s_axis_tready = !r_skid_valid;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign len7       = s_axis_tdata[6:0];
    assign remain_dec = r_remain - LEN_W'(1);

    // Key bytes are taken most significant first.
    always_comb begin
        unique case (r_kidx)
            2'd0: key_byte = r_key[31:24];
            2'd1: key_byte = r_key[23:16];
            2'd2: key_byte = r_key[15:8];
            2'd3: key_byte = r_key[7:0];
        endcase
    end

    // Next state and result for the byte on s_axis.
    always_comb begin
        n_phase   = r_phase;
        n_fin     = r_fin;
        n_opcode  = r_opcode;
        n_masked  = r_masked;
        n_len     = r_len;
        n_hcnt    = r_hcnt;
        n_key     = r_key;
        n_remain  = r_remain;
        n_kidx    = r_kidx;
        res_valid = 1'b0;
        res       = '0;

        unique case (r_phase)
            PH_SECOND: begin
                n_masked = s_axis_tdata[7];
                n_key    = '0;
                n_len    = '0;
                if (len7 == LEN7_EXT16) begin
                    n_hcnt  = CNT_EXT16;
                    n_phase = PH_EXTLEN;
                end else if (len7 == LEN7_EXT64) begin
                    n_hcnt  = CNT_EXT64;
                    n_phase = PH_EXTLEN;
                end else begin
                    n_len = LEN_W'(len7);
                    if (n_masked) begin
                        n_hcnt  = CNT_KEY;
                        n_phase = PH_KEY;
                    end else begin
                        res_valid = 1'b1;
                    end
                end
            end
            PH_EXTLEN: begin
                n_len = {r_len[LEN_W-9:0], s_axis_tdata};
                if (r_hcnt != 3'd0) begin
                    n_hcnt = r_hcnt - 3'd1;
                end else if (r_masked) begin
                    n_hcnt  = CNT_KEY;
                    n_phase = PH_KEY;
                end else begin
                    res_valid = 1'b1;
                end
            end
            PH_KEY: begin
                n_key = {r_key[23:0], s_axis_tdata};
                if (r_hcnt != 3'd0) begin
                    n_hcnt = r_hcnt - 3'd1;
                end else begin
                    res_valid = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                n_kidx       = r_kidx + 2'd1;
                n_remain     = remain_dec;
                res_valid    = 1'b1;
                res.kind     = KIND_PAYLOAD;
                res.fin      = r_fin;
                res.opcode   = r_opcode;
                res.masked   = r_masked;
                res.length   = r_len;
                res.pbyte    = s_axis_tdata ^ (r_masked ? key_byte : 8'h00);
                res.last     = (remain_dec == '0);
                if (res.last) begin
                    n_phase = PH_FIRST;
                end
            end
            default: begin
                // first header byte (also any unused phase code); RSV bits ignored
                n_fin    = s_axis_tdata[7];
                n_opcode = s_axis_tdata[3:0];
                n_phase  = PH_SECOND;
            end
        endcase

        // Header complete: emit header result and arm the payload counter.
        if (res_valid && r_phase != PH_PAYLOAD) begin
            res.kind   = KIND_HEADER;
            res.fin    = n_fin;
            res.opcode = n_opcode;
            res.masked = n_masked;
            res.length = n_len;
            res.pbyte  = '0;
            res.last   = (n_len == '0);
            n_remain   = n_len;
            n_kidx     = 2'd0;
            n_phase    = res.last ? PH_FIRST : PH_PAYLOAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_FIRST;
            r_fin    <= 1'b0;
            r_opcode <= '0;
            r_masked <= 1'b0;
            r_len    <= '0;
            r_hcnt   <= '0;
            r_key    <= '0;
            r_remain <= '0;
            r_kidx   <= '0;
        end else if (in_fire) begin
            r_phase  <= n_phase;
            r_fin    <= n_fin;
            r_opcode <= n_opcode;
            r_masked <= n_masked;
            r_len    <= n_len;
            r_hcnt   <= n_hcnt;
            r_key    <= n_key;
            r_remain <= n_remain;
            r_kidx   <= n_kidx;
        end
    end

    // Output register with skid: a result that finds the output stalled parks in the skid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_fire && res_valid;
            end
        end else if (in_fire && res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || m_axis_tready) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (in_fire && res_valid) begin
            r_skid <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {3'b000, r_out.pbyte, r_out.length, r_out.masked,
                            r_out.opcode, r_out.fin};

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------

    // The skid entry only fills behind a held output entry.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid while output entry empty");

    // In the payload phase at least one byte is still owed.
    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_remain != '0))
        else $error("payload phase with zero bytes remaining");

    // An empty frame closes on its header result.
    a_empty_hdr_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == KIND_HEADER && r_out.length == '0) |-> r_out.last)
        else $error("empty-frame header result without last");

    // A payload result always carries a nonzero frame length.
    a_payload_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && res_valid && res.kind == KIND_PAYLOAD) |-> (res.length != '0))
        else $error("payload byte emitted for an empty frame");

endmodule
